FILE: src/sbid_pkg.sv
// Shared types for the two-level compressed bitmap decoder.
// Holds the controller state type and the command/status bundles.
// No dependencies.
package sbid_pkg;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EMIT
	} sbid_state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;    // take the input word
		logic load_bad;  // load the bad-element result into the output register
		logic emit;      // load the next position into the output register
	} sbid_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic ctrl_word; // input word is read as a control word
		logic elem_zero; // masked element word is zero
		logic elem_last; // one bit left in the held element mask
	} sbid_stat_t;

endpackage

FILE: src/sbid_ctrl.sv
// Controller for the bitmap decoder: handshakes and the idle/emit sequence.
// Depends on sbid_pkg; drives commands to sbid_dp.
module sbid_ctrl
	import sbid_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  sbid_stat_t stat,
	output sbid_cmd_t  cmd
);

	sbid_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;
	logic        out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_stall     = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				// hold input while a result still waits
				in_stall   = !out_free;
				cmd.accept = in_valid && out_free;
				if (cmd.accept && !stat.ctrl_word) begin
					if (stat.elem_zero) begin
						cmd.load_bad = 1'b1;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					if (stat.elem_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (cmd.load_bad || cmd.emit) begin
			out_valid_d = 1'b1;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

endmodule

FILE: src/sbid_dp.sv
// Datapath for the bitmap decoder: chunk base, pending subchunks, element
// mask and the output register. Depends on sbid_pkg; driven by sbid_ctrl.
module sbid_dp
	import sbid_pkg::*;
#(
	parameter int CHUNK_SIZE = 256,
	parameter int SUB_SIZE   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] word,
	input  logic        new_bitmap,
	input  sbid_cmd_t   cmd,
	output sbid_stat_t  stat,
	output logic [31:0] position,
	output logic        last_of_word,
	output logic        bad_element
);

	localparam int SubRatio = CHUNK_SIZE / SUB_SIZE;
	localparam int SubCount = (SubRatio > 32) ? 32 : SubRatio;
	localparam int PidxW    = (SubCount > 1) ? $clog2(SubCount) : 1;
	localparam int EidxW    = $clog2(SUB_SIZE);

	logic [SubCount-1:0] pending_q, pend_eff, pend_next;
	logic [31:0]         base_q, base_eff;
	logic [SUB_SIZE-1:0] elem_q, elem_in;
	logic [31:0]         off_q, off_d;
	logic [SubCount-1:0] ctrl_in;
	logic [PidxW-1:0]    pidx;
	logic [EidxW-1:0]    eidx;
	logic [31:0]         pos_q;
	logic                last_q, bad_q;

	// a restart clears state before the word is looked at
	assign pend_eff  = new_bitmap ? '0 : pending_q;
	assign base_eff  = new_bitmap ? '0 : base_q;
	assign pend_next = pend_eff & (pend_eff - 1'b1);
	assign ctrl_in   = word[SubCount-1:0];
	assign elem_in   = word[SUB_SIZE-1:0];

	always_comb begin
		pidx = '0;
		for (int i = SubCount - 1; i >= 0; i--) begin
			if (pend_eff[i]) begin
				pidx = PidxW'(i);
			end
		end
	end

	always_comb begin
		eidx = '0;
		for (int i = SUB_SIZE - 1; i >= 0; i--) begin
			if (elem_q[i]) begin
				eidx = EidxW'(i);
			end
		end
	end

	assign off_d = base_eff + 32'(pidx) * 32'(SUB_SIZE);

	assign stat.ctrl_word = (pend_eff == '0);
	assign stat.elem_zero = (elem_in == '0);
	assign stat.elem_last = ((elem_q & (elem_q - 1'b1)) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			base_q    <= '0;
		end else if (cmd.accept) begin
			if (pend_eff == '0) begin
				if (ctrl_in == '0) begin
					base_q    <= base_eff + 32'(CHUNK_SIZE);
					pending_q <= '0;
				end else begin
					base_q    <= base_eff;
					pending_q <= ctrl_in;
				end
			end else begin
				pending_q <= pend_next;
				// advance the base once the last subchunk is consumed
				base_q    <= (pend_next == '0) ? base_eff + 32'(CHUNK_SIZE) : base_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			elem_q <= elem_in;
			off_q  <= off_d;
		end else if (cmd.emit) begin
			elem_q <= elem_q & (elem_q - 1'b1);
		end
		if (cmd.load_bad) begin
			pos_q  <= '0;
			last_q <= 1'b1;
			bad_q  <= 1'b1;
		end else if (cmd.emit) begin
			pos_q  <= off_q + 32'(eidx);
			last_q <= stat.elem_last;
			bad_q  <= 1'b0;
		end
	end

	assign position     = pos_q;
	assign last_of_word = last_q;
	assign bad_element  = bad_q;

endmodule

FILE: src/sparse_bitmap_index_decoder.sv
// Top level of the two-level compressed bitmap decoder.
// Instantiates sbid_ctrl and sbid_dp; uses sbid_pkg.
//
// channel  direction  handshake             payload
// input    in         in_valid / in_stall   word[31:0], new_bitmap
// output   out        out_valid / out_stall position[31:0], last_of_word, bad_element
//
// A control word gives no beat. An element word is loaded, then gives one beat
// per set bit, each set bit found by a priority encoder over the held mask; a
// zero element word loads its single beat as it is accepted.
// One item is in work at a time; the next word is taken at the edge where the
// last beat leaves.
// arst_n clears the chunk base, pending subchunks, controller state and output valid.
// A stalled output holds its beat and stalls the sequence behind it.
module sparse_bitmap_index_decoder
	import sbid_pkg::*;
#(
	parameter int CHUNK_SIZE = 256,
	parameter int SUB_SIZE   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] word,
	input  logic        new_bitmap,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] position,
	output logic        last_of_word,
	output logic        bad_element
);

	sbid_cmd_t  cmd;
	sbid_stat_t stat;

	sbid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	sbid_dp #(
		.CHUNK_SIZE (CHUNK_SIZE),
		.SUB_SIZE   (SUB_SIZE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.word         (word),
		.new_bitmap   (new_bitmap),
		.cmd          (cmd),
		.stat         (stat),
		.position     (position),
		.last_of_word (last_of_word),
		.bad_element  (bad_element)
	);

endmodule
